// ----- rtl/vector_l2_normalize_top_defines.svh -----
// assertion macros used by the checker file
// no dependencies; pulled in by include where assertions are written
`ifndef VECTOR_L2_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR_L2_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define VL2N_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define VL2N_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/vl2n_pkg.sv -----
// shared types and constants of the l2 normalize block
// no dependencies; used by every module of the block but vl2n_ram
`timescale 1ns / 1ps

package vl2n_pkg;

    localparam int VECTOR_LEN_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int EPS_W            = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
    localparam int NORM_W           = 18;
    localparam int Q_W              = 16;
    localparam int M_TDATA_W        = 40;

    typedef enum logic [2:0] {
        ST_INGEST,
        ST_ACCUM,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_READ,
        ST_DIV_LOAD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic ingest;
        logic sqrt_load;
        logic sqrt_step;
        logic rd_issue;
        logic div_load;
        logic div_step;
        logic rd_next;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic close_in;
        logic sqrt_done;
        logic div_done;
        logic last_rd;
    } sts_t;

endpackage

// ----- rtl/vl2n_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module vl2n_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/vl2n_ctrl.sv -----
// sequencer of the l2 normalize block: ingest, root, per-item divide, output
// depends on vl2n_pkg
`timescale 1ns / 1ps

module vl2n_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            m_ready,
    input  vl2n_pkg::sts_t  sts,
    output vl2n_pkg::cmd_t  cmd,
    output logic            s_ready,
    output logic            m_valid
);

    vl2n_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vl2n_pkg::ST_INGEST;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vl2n_pkg::ST_INGEST: begin
                if (s_valid && sts.close_in) state_next = vl2n_pkg::ST_ACCUM;
            end
            vl2n_pkg::ST_ACCUM:     state_next = vl2n_pkg::ST_SQRT_LOAD;
            vl2n_pkg::ST_SQRT_LOAD: state_next = vl2n_pkg::ST_SQRT;
            vl2n_pkg::ST_SQRT: begin
                if (sts.sqrt_done) state_next = vl2n_pkg::ST_READ;
            end
            vl2n_pkg::ST_READ:      state_next = vl2n_pkg::ST_DIV_LOAD;
            vl2n_pkg::ST_DIV_LOAD:  state_next = vl2n_pkg::ST_DIV;
            vl2n_pkg::ST_DIV: begin
                if (sts.div_done) state_next = vl2n_pkg::ST_OUT;
            end
            vl2n_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = sts.last_rd ? vl2n_pkg::ST_INGEST : vl2n_pkg::ST_READ;
                end
            end
            default: state_next = vl2n_pkg::ST_INGEST;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        unique case (state_reg)
            vl2n_pkg::ST_INGEST: begin
                s_ready    = 1'b1;
                cmd.ingest = s_valid;
            end
            vl2n_pkg::ST_ACCUM:     ;
            vl2n_pkg::ST_SQRT_LOAD: cmd.sqrt_load = 1'b1;
            vl2n_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
            vl2n_pkg::ST_READ:      cmd.rd_issue  = 1'b1;
            vl2n_pkg::ST_DIV_LOAD:  cmd.div_load  = 1'b1;
            vl2n_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            vl2n_pkg::ST_OUT: begin
                m_valid     = 1'b1;
                cmd.rd_next = m_ready && !sts.last_rd;
                cmd.clear   = m_ready && sts.last_rd;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/vl2n_dp.sv -----
// datapath: sample store, sum of squares, bit-serial root, bit-serial divider
// depends on vl2n_pkg and vl2n_ram
`timescale 1ns / 1ps

module vl2n_dp #(
    parameter int VECTOR_LEN   = vl2n_pkg::VECTOR_LEN_DEF,
    parameter int SAMPLE_WIDTH = vl2n_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vl2n_pkg::cmd_t                cmd,
    output vl2n_pkg::sts_t                sts,
    input  logic [SAMPLE_WIDTH-1:0]       in_sample,
    input  logic                          in_final,
    input  logic                          cfg_we,
    input  logic [vl2n_pkg::EPS_W-1:0]    cfg_eps,
    output logic [vl2n_pkg::Q_W-1:0]      out_norm_q,
    output logic [vl2n_pkg::NORM_W-1:0]   out_norm_value
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int SUM_W  = (2 * SW + 7 > 64) ? 64 : 2 * SW + 7;
    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int CNT_W  = $clog2(VECTOR_LEN + 1);
    localparam int IDX_W  = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int SQC_W  = $clog2(ROOT_W);
    localparam int DVC_W  = $clog2(vl2n_pkg::Q_W);
    localparam int CMP_W  = ((SW > ROOT_W) ? SW : ROOT_W) + 1;
    localparam int QW     = vl2n_pkg::Q_W;

    // configuration
    logic [vl2n_pkg::EPS_W-1:0] eps_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) eps_reg <= vl2n_pkg::EPS_RESET;
        else if (cfg_we) eps_reg <= cfg_eps;
    end

    // ingest: magnitude, square, accumulate
    logic [SW-1:0]    in_mag;
    logic [2*SW-1:0]  sq_reg;
    logic             sq_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W:0]   eps_add;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_idx_reg;

    assign in_mag  = in_sample[SW-1] ? (~in_sample + 1'b1) : in_sample;
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);
    assign eps_add = {1'b0, sum_reg} + (SUM_W + 1)'(eps_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
        end else begin
            sq_valid_reg <= cmd.ingest;
            if (cmd.sqrt_load) begin
                sum_reg <= '0;
            end else if (sq_valid_reg) begin
                sum_reg <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            end
            if (cmd.ingest) count_reg <= count_reg + 1'b1;
            else if (cmd.clear) count_reg <= '0;
            if (cmd.clear) rd_idx_reg <= '0;
            else if (cmd.rd_next) rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ingest) sq_reg <= in_mag * in_mag;
    end

    // sample store
    logic [SW-1:0] rd_data;
    vl2n_ram #(.WIDTH(SW), .DEPTH(VECTOR_LEN)) u_store (
        .clk   (aclk),
        .we    (cmd.ingest),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (in_sample),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // floor square root, two radicand bits per step
    logic [2*ROOT_W-1:0] rt_v_reg;
    logic [ROOT_W+1:0]   rt_rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQC_W-1:0]    rt_cnt_reg;
    logic [ROOT_W+3:0]   rt_sh;
    logic [ROOT_W+3:0]   rt_trial;
    logic [ROOT_W+3:0]   rt_diff;

    assign rt_sh    = {rt_rem_reg, rt_v_reg[2*ROOT_W-1 -: 2]};
    assign rt_trial = {2'b00, root_reg, 2'b01};
    assign rt_diff  = rt_sh - rt_trial;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_load) begin
            rt_v_reg   <= (2 * ROOT_W)'(eps_add[SUM_W] ? {SUM_W{1'b1}} : eps_add[SUM_W-1:0]);
            rt_rem_reg <= '0;
            root_reg   <= '0;
            rt_cnt_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rt_v_reg   <= {rt_v_reg[2*ROOT_W-3:0], 2'b00};
            rt_cnt_reg <= rt_cnt_reg + 1'b1;
            if (rt_sh >= rt_trial) begin
                rt_rem_reg <= rt_diff[ROOT_W+1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rt_rem_reg <= rt_sh[ROOT_W+1:0];
                root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // restoring divide of |sample| * 2^15 by the norm, one quotient bit per step
    logic [SW-1:0]     dv_mag;
    logic [CMP_W-1:0]  dv_lhs;
    logic [CMP_W-1:0]  dv_rhs;
    logic [ROOT_W-1:0] dv_rem_reg;
    logic [QW-1:0]     dv_dvd_reg;
    logic [QW-1:0]     dv_q_reg;
    logic [DVC_W-1:0]  dv_cnt_reg;
    logic              dv_neg_reg;
    logic              dv_sat_reg;
    logic              dv_zero_reg;
    logic [ROOT_W:0]   dv_sh;
    logic [ROOT_W:0]   dv_diff;

    assign dv_mag  = rd_data[SW-1] ? (~rd_data + 1'b1) : rd_data;
    assign dv_lhs  = CMP_W'(dv_mag);
    assign dv_rhs  = CMP_W'({root_reg, 1'b0});
    assign dv_sh   = {dv_rem_reg, dv_dvd_reg[QW-1]};
    assign dv_diff = dv_sh - {1'b0, root_reg};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dv_neg_reg  <= rd_data[SW-1];
            dv_zero_reg <= (root_reg == '0);
            dv_sat_reg  <= (dv_lhs >= dv_rhs);
            dv_rem_reg  <= ROOT_W'(dv_mag >> 1);
            dv_dvd_reg  <= {dv_mag[0], {(QW - 1){1'b0}}};
            dv_q_reg    <= '0;
            dv_cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            dv_dvd_reg <= {dv_dvd_reg[QW-2:0], 1'b0};
            dv_cnt_reg <= dv_cnt_reg + 1'b1;
            if (dv_sh >= {1'b0, root_reg}) begin
                dv_rem_reg <= dv_diff[ROOT_W-1:0];
                dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b1};
            end else begin
                dv_rem_reg <= dv_sh[ROOT_W-1:0];
                dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b0};
            end
        end
    end

    // sign and saturation of the q1.15 result
    localparam logic [QW-1:0] Q_POS_MAX = {1'b0, {(QW - 1){1'b1}}};
    localparam logic [QW-1:0] Q_NEG_MAX = {1'b1, {(QW - 1){1'b0}}};

    always_comb begin
        if (dv_zero_reg) begin
            out_norm_q = '0;
        end else if (dv_neg_reg) begin
            out_norm_q = (dv_sat_reg || dv_q_reg > Q_NEG_MAX) ? Q_NEG_MAX : (~dv_q_reg + 1'b1);
        end else begin
            out_norm_q = (dv_sat_reg || dv_q_reg > Q_POS_MAX) ? Q_POS_MAX : dv_q_reg;
        end
    end

    assign out_norm_value = (ROOT_W'(root_reg) > ROOT_W'({vl2n_pkg::NORM_W{1'b1}}))
                          ? {vl2n_pkg::NORM_W{1'b1}} : vl2n_pkg::NORM_W'(root_reg);

    assign sts.close_in  = in_final || (count_reg == CNT_W'(VECTOR_LEN - 1));
    assign sts.sqrt_done = cmd.sqrt_step && (rt_cnt_reg == SQC_W'(ROOT_W - 1));
    assign sts.div_done  = cmd.div_step && (dv_cnt_reg == DVC_W'(QW - 1));
    assign sts.last_rd   = ((rd_idx_reg + 1'b1) == count_reg);

endmodule

// ----- rtl/vector_l2_normalize_top.sv -----
// top level of the l2 normalize block
// depends on vl2n_pkg, vl2n_ctrl, vl2n_dp (and vl2n_ram below it)
`timescale 1ns / 1ps
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata: sample, s_tlast: is_final
//  m_        out        m_tvalid/m_tready   m_tdata: normalized, norm_value; m_tlast: end
//  cfg_      in         cfg_valid/cfg_ready cfg_data: epsilon (always ready)
//
//  samples are taken one per cycle while s_tready is high; a vector closes on s_tlast or
//  when the store fills; then come the accumulate and root load states and the serial root,
//  one root bit per cycle, (SUM_W+1)/2 bits with SUM_W = min(64, 2*SAMPLE_WIDTH+7), i.e. 20
//  at the default width; each result runs through store read, divider load, 16 divide
//  steps and output, one quotient bit per step; a stalled m_tready holds the result
//  no input is taken from closing a vector until its last result is delivered
//  reset is synchronous, active low; the store needs no clearing

module vector_l2_normalize_top #(
    parameter int VECTOR_LEN   = vl2n_pkg::VECTOR_LEN_DEF,
    parameter int SAMPLE_WIDTH = vl2n_pkg::SAMPLE_WIDTH_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,   // sample
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vl2n_pkg::M_TDATA_W-1:0]   m_tdata,   // normalized[15:0], norm_value[33:16]
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vl2n_pkg::EPS_W-1:0]       cfg_data
);

    vl2n_pkg::cmd_t cmd;
    vl2n_pkg::sts_t sts;

    logic [vl2n_pkg::Q_W-1:0]    norm_q;
    logic [vl2n_pkg::NORM_W-1:0] norm_value;

    // epsilon is taken in any cycle
    assign cfg_ready = 1'b1;

    vl2n_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .m_ready (m_tready),
        .sts     (sts),
        .cmd     (cmd),
        .s_ready (s_tready),
        .m_valid (m_tvalid)
    );

    vl2n_dp #(
        .VECTOR_LEN   (VECTOR_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_sample      (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_final       (s_tlast),
        .cfg_we         (cfg_valid),
        .cfg_eps        (cfg_data),
        .out_norm_q     (norm_q),
        .out_norm_value (norm_value)
    );

    // pack the result item, zero filled to whole bytes
    assign m_tdata = vl2n_pkg::M_TDATA_W'({norm_value, norm_q});
    // the last result of the vector is the one at the last written store index
    assign m_tlast = sts.last_rd;

endmodule

// ----- rtl/vl2n_checker.sv -----
// port-level checks on the l2 normalize block, bound to the top level
// depends on vl2n_pkg and vector_l2_normalize_top_defines.svh
`timescale 1ns / 1ps
`include "vector_l2_normalize_top_defines.svh"

module vl2n_checker #(
    parameter int SAMPLE_WIDTH = vl2n_pkg::SAMPLE_WIDTH_DEF,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [S_TDATA_W-1:0]           s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vl2n_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    `VL2N_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `VL2N_ASSERT_NEXT(a_s_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "input item dropped")
    `VL2N_ASSERT_SAME(a_no_overlap, m_tvalid, !s_tready, "input taken while a result is pending")
    `VL2N_ASSERT_NEXT(a_close_stops, s_tvalid && s_tready && s_tlast, !s_tready, "input taken after vector closed")
    `VL2N_ASSERT_NEXT(a_more_follow, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid, "vector ended early")

endmodule

bind vector_l2_normalize_top vl2n_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_vl2n_checker (.*);

// ----- dv/testbench.sv -----
// self-checking testbench for the l2 normalize block, streams vectors with random stalls
// depends on vl2n_pkg and vector_l2_normalize_top; scoreboard class predicts every result
`timescale 1ns / 1ps

module testbench;

    localparam int VLEN      = vl2n_pkg::VECTOR_LEN_DEF;
    localparam int CYCLE_MAX = 1000000;
    localparam int DRAIN     = 80;

    typedef struct {
        logic [vl2n_pkg::Q_W-1:0]    quotient;
        logic [vl2n_pkg::NORM_W-1:0] norm;
        logic                        last;
    } norm_result_t;

    // predicts the normalized stream and checks each delivered item against it
    class norm_scoreboard;
        logic signed [15:0]          samples[VLEN];
        int                          count;
        logic [36:0]                 sq_sum;
        logic [vl2n_pkg::EPS_W-1:0]  eps;
        norm_result_t                pending[$];
        int                          errors;

        function new();
            count  = 0;
            sq_sum = '0;
            eps    = vl2n_pkg::EPS_RESET;
            errors = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function void note_sample(logic [15:0] raw, logic fin);
            longint          s;
            longint unsigned root;
            longint          q;
            norm_result_t    r;
            s = longint'($signed(raw));
            if (count < VLEN) begin
                samples[count] = $signed(raw);
                count++;
            end
            sq_sum = sq_sum + 37'(s * s);
            if (!fin && count < VLEN) return;
            root = isqrt(longint'(sq_sum) + longint'(eps));
            for (int k = 0; k < count; k++) begin
                q = 0;
                if (root != 0) begin
                    q = (longint'(samples[k]) * 32768) / longint'(root);
                    if (q > 32767) q = 32767;
                    if (q < -32768) q = -32768;
                end
                r.quotient = q[15:0];
                r.norm     = (root > 262143) ? 18'h3ffff : root[17:0];
                r.last     = (k + 1 == count);
                pending.push_back(r);
            end
            count  = 0;
            sq_sum = '0;
        endfunction

        function void check_result(logic [vl2n_pkg::M_TDATA_W-1:0] data, logic last);
            norm_result_t r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b", $time, data, last);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (data[15:0] !== r.quotient) begin
                $display("%0t: normalized expected %h actual %h", $time, r.quotient, data[15:0]);
                errors++;
            end
            if (data[33:16] !== r.norm) begin
                $display("%0t: norm expected %h actual %h", $time, r.norm, data[33:16]);
                errors++;
            end
            if (last !== r.last) begin
                $display("%0t: end flag expected %b actual %b", $time, r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;   // sample
    logic                           s_tlast;   // is_final
    logic                           m_tvalid;
    logic                           m_tready;
    logic [vl2n_pkg::M_TDATA_W-1:0] m_tdata;   // normalized[15:0], norm_value[33:16]
    logic                           m_tlast;   // end of vector
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [vl2n_pkg::EPS_W-1:0]     cfg_data;  // epsilon

    norm_scoreboard sb;
    int src_idle_pct;   // sender gap chance per cycle
    int snk_idle_pct;   // receiver stall chance per cycle
    int hold_cycles;    // requested long receiver hold-off
    int cycle_count;

    vector_l2_normalize_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted down here
    int hold_left = 0;
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_left   = hold_cycles;
            hold_cycles = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitors: accepted input items feed the predictor, results get checked
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_sample(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // one sample item; gaps only lower valid, never in the same step as a raise
    task automatic send_sample(logic [15:0] value, logic fin);
        forever begin
            @(negedge aclk);
            if ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= value;
                s_tlast  <= fin;
                break;
            end
        end
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // sender waits until every expected item has come, then lets the block settle
    task automatic drain();
        stop_sending();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_epsilon(logic [vl2n_pkg::EPS_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.eps = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(16)) - 8);
            3:       return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly short vectors, now and then one that fills the store
    task automatic random_vectors(int n_items);
        int sent;
        int len;
        bit marked;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(19) == 0) begin
                len    = VLEN;
                marked = 1'($urandom_range(1));
            end else begin
                len    = $urandom_range(8, 1);
                marked = 1'b1;
            end
            for (int i = 0; i < len; i++)
                send_sample(pick_sample(), marked && (i == len - 1));
            sent += len;
        end
    endtask

    initial begin
        sb           = new();
        cycle_count  = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes with the reset epsilon
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hffff, 1'b1);
        drain();
        // zero epsilon: all-zero vector gives zero norm
        write_epsilon(16'd0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        // single sample equal to the norm: quotient of plus one saturates
        send_sample(16'd12345, 1'b1);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0003, 1'b0);
        send_sample(16'h0004, 1'b1);
        drain();

        // phase one: sender idles less than receiver, largest epsilon
        write_epsilon(16'hffff);
        src_idle_pct = 29;
        snk_idle_pct = 48;
        random_vectors(85);
        drain();

        // phase two: swapped idling, random epsilon
        write_epsilon(16'($urandom));
        src_idle_pct = 48;
        snk_idle_pct = 29;
        random_vectors(85);
        drain();

        // phase three: no idling, long receiver hold-off while input keeps coming
        write_epsilon(16'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_cycles  = 400;
        random_vectors(85);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vl2n_pkg.sv
rtl/vl2n_ram.sv
rtl/vl2n_ctrl.sv
rtl/vl2n_dp.sv
rtl/vector_l2_normalize_top.sv
rtl/vl2n_checker.sv
dv/testbench.sv
